@@ sv/hrsp_pkg.sv @@
// Shared types and constants for the HTTP request stream parser.
// Holds the result beat type, byte roles, character codes and the header name table.
// No dependencies; every other file imports this package.
package hrsp_pkg;

	// Default sizing handed to the top level parameters
	localparam int LENGTH_BITS_DEF      = 32;
	localparam int SPACE_COUNT_BITS_DEF = 8;

	// Reset value of the max_body_length register
	localparam logic [31:0] MAX_BODY_RESET = 32'd65536;

	// Length of the header name "content-length"
	localparam logic [3:0] NAME_LEN = 4'd14;

	// Character codes
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	// Byte roles
	localparam logic [2:0] ROLE_METHOD  = 3'd0;
	localparam logic [2:0] ROLE_TARGET  = 3'd1;
	localparam logic [2:0] ROLE_VERSION = 3'd2;
	localparam logic [2:0] ROLE_NAME    = 3'd3;
	localparam logic [2:0] ROLE_VALUE   = 3'd4;
	localparam logic [2:0] ROLE_BODY    = 3'd5;
	localparam logic [2:0] ROLE_DELIM   = 3'd6;

	// One result beat
	typedef struct packed {
		logic [7:0]  byte_out;
		logic [2:0]  byte_role;
		logic [7:0]  held_spaces;
		logic        token_end;
		logic        headers_done;
		logic [31:0] body_length;
		logic        message_end;
		logic        format_error;
	} hrsp_result_t;

	// Lower-case characters of "content-length", by position
	function automatic logic [7:0] name_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h63; // c
			4'd1:    c = 8'h6F; // o
			4'd2:    c = 8'h6E; // n
			4'd3:    c = 8'h74; // t
			4'd4:    c = 8'h65; // e
			4'd5:    c = 8'h6E; // n
			4'd6:    c = 8'h74; // t
			4'd7:    c = 8'h2D; // -
			4'd8:    c = 8'h6C; // l
			4'd9:    c = 8'h65; // e
			4'd10:   c = 8'h6E; // n
			4'd11:   c = 8'h67; // g
			4'd12:   c = 8'h74; // t
			4'd13:   c = 8'h68; // h
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

@@ sv/hrsp_len_acc.sv @@
// Decimal length accumulate step: acc * 10 + digit, saturating at the limit.
// The times-ten product is built from two shifts and an add.
// Depends on hrsp_pkg.
module hrsp_len_acc #(
	parameter int LENGTH_BITS = 32
) (
	input  logic [LENGTH_BITS-1:0] acc,
	input  logic [3:0]             digit,
	input  logic [LENGTH_BITS-1:0] limit,
	output logic [LENGTH_BITS-1:0] acc_next,
	output logic                   saturated
);
	import hrsp_pkg::*;

	localparam int SW = LENGTH_BITS + 4;

	logic [SW-1:0] sum;

	// Form acc*8 + acc*2 + digit without overflow, then compare to the limit
	assign sum       = (SW'(acc) << 3) + (SW'(acc) << 1) + SW'(digit);
	assign saturated = sum > SW'(limit);
	assign acc_next  = saturated ? limit : sum[LENGTH_BITS-1:0];

endmodule

@@ sv/hrsp_core.sv @@
// Parser state registers and the per-byte next-state and result logic.
// Handles one byte per enabled cycle; the result is combinational from the state.
// Depends on hrsp_pkg and hrsp_len_acc.
module hrsp_core #(
	parameter int LENGTH_BITS      = hrsp_pkg::LENGTH_BITS_DEF,
	parameter int SPACE_COUNT_BITS = hrsp_pkg::SPACE_COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [7:0]             stream_byte,
	input  logic                   restart,
	input  logic [LENGTH_BITS-1:0] limit,
	output hrsp_pkg::hrsp_result_t result
);
	import hrsp_pkg::*;

	localparam logic [2:0] PH_METHOD  = 3'd0;
	localparam logic [2:0] PH_TARGET  = 3'd1;
	localparam logic [2:0] PH_VERSION = 3'd2;
	localparam logic [2:0] PH_NAME    = 3'd3;
	localparam logic [2:0] PH_VALUE   = 3'd4;
	localparam logic [2:0] PH_BODY    = 3'd5;

	localparam int CW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;
	localparam int HW = (SPACE_COUNT_BITS > 8) ? SPACE_COUNT_BITS : 8;

	// State registers
	logic [2:0]                  phase_q;
	logic                        cr_seen_q;
	logic                        line_empty_q;
	logic [3:0]                  match_idx_q;
	logic                        still_match_q;
	logic                        len_hdr_q;
	logic                        value_begun_q;
	logic [SPACE_COUNT_BITS-1:0] spaces_q;
	logic [LENGTH_BITS-1:0]      acc_q;
	logic [LENGTH_BITS-1:0]      left_q;

	// State seen by this byte (after an optional restart)
	logic [2:0]                  ph;
	logic                        crs, lie, nsm, ilh, vb;
	logic [3:0]                  nmi;
	logic [SPACE_COUNT_BITS-1:0] psc;
	logic [LENGTH_BITS-1:0]      acc, bbl;

	// Next state
	logic [2:0]                  ph_n;
	logic                        crs_n, lie_n, nsm_n, ilh_n, vb_n;
	logic [3:0]                  nmi_n;
	logic [SPACE_COUNT_BITS-1:0] psc_n;
	logic [LENGTH_BITS-1:0]      acc_n, bbl_n, left_dec;

	logic [7:0]             lc;
	logic                   is_digit;
	logic [LENGTH_BITS-1:0] acc_step;
	logic                   acc_sat;
	logic [CW-1:0]          acc_ext;
	logic [HW-1:0]          psc_ext;

	// Apply restart before the byte is handled
	always_comb begin
		if (restart) begin
			ph  = PH_METHOD;
			crs = 1'b0;
			lie = 1'b1;
			nmi = 4'd0;
			nsm = 1'b1;
			ilh = 1'b0;
			vb  = 1'b0;
			psc = '0;
			acc = '0;
			bbl = '0;
		end else begin
			ph  = phase_q;
			crs = cr_seen_q;
			lie = line_empty_q;
			nmi = match_idx_q;
			nsm = still_match_q;
			ilh = len_hdr_q;
			vb  = value_begun_q;
			psc = spaces_q;
			acc = acc_q;
			bbl = left_q;
		end
	end

	assign lc       = (stream_byte >= CH_UP_A && stream_byte <= CH_UP_Z) ?
		stream_byte + CASE_OFS : stream_byte;
	assign is_digit = stream_byte >= CH_ZERO && stream_byte <= CH_NINE;
	assign acc_ext  = CW'(acc);
	assign psc_ext  = HW'(psc);
	assign left_dec = bbl - 1'b1;

	hrsp_len_acc #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_len_acc (
		.acc      (acc),
		.digit    (stream_byte[3:0]),
		.limit    (limit),
		.acc_next (acc_step),
		.saturated(acc_sat)
	);

	// Classify the byte and work out the next state
	always_comb begin
		ph_n  = ph;
		crs_n = crs;
		lie_n = lie;
		nmi_n = nmi;
		nsm_n = nsm;
		ilh_n = ilh;
		vb_n  = vb;
		psc_n = psc;
		acc_n = acc;
		bbl_n = bbl;

		result              = '0;
		result.byte_out     = stream_byte;
		result.byte_role    = ROLE_DELIM;

		if (ph == PH_BODY) begin
			// Count down the body; the last byte ends the message
			result.byte_role = ROLE_BODY;
			bbl_n            = left_dec;
			if (left_dec == '0) begin
				result.message_end = 1'b1;
				ph_n  = PH_METHOD;
				crs_n = 1'b0;
				lie_n = 1'b1;
				nmi_n = 4'd0;
				nsm_n = 1'b1;
				ilh_n = 1'b0;
				vb_n  = 1'b0;
				psc_n = '0;
				acc_n = '0;
				bbl_n = '0;
			end
		end else if (stream_byte == CH_CR) begin
			crs_n = 1'b1;
		end else if (stream_byte == CH_LF) begin
			// A line ends only at CR LF; a bare LF is dropped
			if (crs) begin
				crs_n = 1'b0;
				lie_n = 1'b1;
				nmi_n = 4'd0;
				nsm_n = 1'b1;
				ilh_n = 1'b0;
				vb_n  = 1'b0;
				psc_n = '0;
				if (ph == PH_NAME) begin
					if (lie) begin
						result.headers_done = 1'b1;
						result.body_length  = acc_ext[31:0];
						if (acc == '0) begin
							result.message_end = 1'b1;
							ph_n  = PH_METHOD;
							acc_n = '0;
							bbl_n = '0;
						end else begin
							bbl_n = acc;
							ph_n  = PH_BODY;
						end
					end else begin
						result.format_error = 1'b1;
					end
				end else begin
					result.token_end = 1'b1;
					ph_n             = PH_NAME;
				end
			end
		end else begin
			crs_n = 1'b0;
			lie_n = 1'b0;
			case (ph)
				PH_METHOD, PH_TARGET: begin
					if (stream_byte == CH_SPACE) begin
						result.token_end = 1'b1;
						ph_n             = ph + 3'd1;
					end else begin
						result.byte_role = (ph == PH_METHOD) ? ROLE_METHOD : ROLE_TARGET;
					end
				end
				PH_VERSION: begin
					// Extra spaces are dropped and do not end the version
					if (stream_byte != CH_SPACE)
						result.byte_role = ROLE_VERSION;
				end
				PH_NAME: begin
					if (stream_byte == CH_COLON) begin
						result.token_end = 1'b1;
						ilh_n            = nsm && nmi == NAME_LEN;
						if (nsm && nmi == NAME_LEN)
							acc_n = '0;
						ph_n  = PH_VALUE;
						vb_n  = 1'b0;
						psc_n = '0;
					end else begin
						result.byte_role = ROLE_NAME;
						if (nsm) begin
							if (nmi < NAME_LEN && lc == name_char(nmi))
								nmi_n = nmi + 4'd1;
							else
								nsm_n = 1'b0;
						end
					end
				end
				PH_VALUE: begin
					if (stream_byte == CH_SPACE) begin
						// Hold back spaces; leading ones are dropped
						if (vb && psc != '1)
							psc_n = psc + 1'b1;
					end else begin
						result.byte_role   = ROLE_VALUE;
						result.held_spaces = (psc_ext > HW'(255)) ? 8'hFF : psc_ext[7:0];
						if (ilh) begin
							if (psc != '0 || !is_digit) begin
								ilh_n = 1'b0;
							end else begin
								acc_n               = acc_step;
								result.format_error = acc_sat;
							end
						end
						psc_n = '0;
						vb_n  = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Advance the state on each handled byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_METHOD;
			cr_seen_q     <= 1'b0;
			line_empty_q  <= 1'b1;
			match_idx_q   <= 4'd0;
			still_match_q <= 1'b1;
			len_hdr_q     <= 1'b0;
			value_begun_q <= 1'b0;
			spaces_q      <= '0;
			acc_q         <= '0;
			left_q        <= '0;
		end else if (en) begin
			phase_q       <= ph_n;
			cr_seen_q     <= crs_n;
			line_empty_q  <= lie_n;
			match_idx_q   <= nmi_n;
			still_match_q <= nsm_n;
			len_hdr_q     <= ilh_n;
			value_begun_q <= vb_n;
			spaces_q      <= psc_n;
			acc_q         <= acc_n;
			left_q        <= bbl_n;
		end
	end

endmodule

@@ sv/http_request_stream_parser_core.sv @@
// HTTP request stream parser, top level.
// Input beats carry one request byte each (s_tdata) with a restart flag (s_tuser).
// Every input beat yields exactly one output beat: the byte, its role (method,
// target, version, header name, header value, body or delimiter), the count of
// interior value spaces held back before it, and token / header / message marks.
// m_tlast marks the last byte of a request; the parsed Content-Length comes out
// on the beat that ends the blank line.
// The cfg channel writes max_body_length (always ready); write it while idle.
// Input beats pass through the input register, then the parser logic into the
// output register. Throughput: one byte per cycle while the receiver is ready,
// with the state update, times-ten length add included, computed combinationally.
// Reset clears both pipeline valid flags and all parser state, and sets the
// length limit to 65536. When the receiver stalls, the output beat holds and
// the input register, if empty, still takes one more beat before s_tready drops.
// Depends on hrsp_pkg, hrsp_core and hrsp_len_acc.
module http_request_stream_parser_core #(
	parameter int LENGTH_BITS      = hrsp_pkg::LENGTH_BITS_DEF,
	parameter int SPACE_COUNT_BITS = hrsp_pkg::SPACE_COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] stream_byte
	input  logic [0:0]  s_tuser,  // [0] restart
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // [7:0] byte_out, [15:8] held_spaces, [47:16] body_length
	output logic [5:0]  m_tuser,  // [2:0] byte_role, [3] token_end, [4] headers_done,
	                              // [5] format_error
	output logic        m_tlast,  // message_end
	// Configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data  // max_body_length
);
	import hrsp_pkg::*;

	localparam int CW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;
	localparam logic [CW-1:0] MASK_EXT = CW'({LENGTH_BITS{1'b1}});
	localparam logic [CW-1:0] RST_EXT  = CW'(MAX_BODY_RESET);
	localparam logic [LENGTH_BITS-1:0] LIMIT_RESET =
		(RST_EXT > MASK_EXT) ? MASK_EXT[LENGTH_BITS-1:0] : RST_EXT[LENGTH_BITS-1:0];

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   restart_s1;
	logic                   valid_s2;
	hrsp_result_t           result_s2;
	hrsp_result_t           result;
	logic                   adv_s1;
	logic [LENGTH_BITS-1:0] limit_q;
	logic [CW-1:0]          cfg_ext;

	assign adv_s1    = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || adv_s1;
	assign cfg_ready = 1'b1;
	assign cfg_ext   = CW'(cfg_data);

	// Hold the effective limit: the register clipped to the length width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= (cfg_ext > MASK_EXT) ? MASK_EXT[LENGTH_BITS-1:0]
			                                : cfg_ext[LENGTH_BITS-1:0];
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1    <= s_tdata;
			restart_s1 <= s_tuser[0];
		end
	end

	hrsp_core #(
		.LENGTH_BITS     (LENGTH_BITS),
		.SPACE_COUNT_BITS(SPACE_COUNT_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv_s1),
		.stream_byte(byte_s1),
		.restart    (restart_s1),
		.limit      (limit_q),
		.result     (result)
	);

	// Output register: load on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			result_s2 <= result;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {result_s2.body_length, result_s2.held_spaces, result_s2.byte_out};
	assign m_tuser  = {result_s2.format_error, result_s2.headers_done,
		result_s2.token_end, result_s2.byte_role};
	assign m_tlast  = result_s2.message_end;

endmodule

@@ tb/sv/http_request_stream_parser_core_tb.sv @@
// Testbench for the HTTP request stream parser core: directed table, then random requests.
// Each result beat is checked against the in-bench byte tagger or a pinned row; depends on hrsp_pkg and the RTL.
`timescale 1ns / 100ps

module http_request_stream_parser_core_tb;
	import hrsp_pkg::*;

	localparam int LEN_W = 32;
	localparam int SPC_W = 8;
	localparam int IDLE_PCT = 33;
	localparam int BODY_CAP = 20;
	localparam int PLAN_STEPS = 6;
	localparam int STEP_BYTES = 25;

	localparam logic [8*14-1:0] LEN_HDR = "content-length";
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;
	localparam logic [7:0] SPACE_MAX = 8'hFF;

	typedef enum logic [2:0] {
		PH_METHOD, PH_TARGET, PH_VERSION, PH_NAME, PH_VALUE, PH_BODY
	} phase_t;

	typedef struct packed {
		logic [7:0]   data;
		logic         rst;
		logic         pinned;
		hrsp_result_t res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [5:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;

	// Byte tagger state, kept in step with the accepted input beats
	phase_t      ph;
	logic        cr_seen;
	logic        line_empty;
	logic [3:0]  match_idx;
	logic        still_match;
	logic        len_hdr;
	logic        val_begun;
	logic [7:0]  pend_sp;
	logic [31:0] len_acc;
	logic [31:0] body_left;
	logic [31:0] max_len;

	hrsp_result_t expected_beats[$];
	stim_row_t    stim_rows[$];
	int           fail_count = 0;
	int           beats_seen = 0;
	int           bytes_sent = 0;
	bit           no_idle = 1'b0;
	bit           restart_next = 1'b0;
	bit           long_gap_done = 1'b0;

	http_request_stream_parser_core #(
		.LENGTH_BITS      (LEN_W),
		.SPACE_COUNT_BITS (SPC_W)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// Hard stop in case the pipeline hangs
	initial begin
		#6000000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [7:0] name_byte(input int i);
		return LEN_HDR[8*(13 - i) +: 8];
	endfunction

	function automatic void line_clear();
		line_empty = 1'b1;
		match_idx = '0;
		still_match = 1'b1;
		len_hdr = 1'b0;
		val_begun = 1'b0;
		pend_sp = '0;
	endfunction

	function automatic void parser_clear();
		ph = PH_METHOD;
		cr_seen = 1'b0;
		line_clear();
		len_acc = '0;
		body_left = '0;
	endfunction

	// Tag one byte and advance the tagger state
	function automatic hrsp_result_t parse_byte(input logic [7:0] b, input logic rst);
		hrsp_result_t r;
		logic [7:0]   lc;
		logic [63:0]  d;
		logic [63:0]  lim;
		r = '0;
		r.byte_out = b;
		r.byte_role = ROLE_DELIM;
		lim = {32'd0, max_len};
		if (rst)
			parser_clear();
		if (ph == PH_BODY) begin
			r.byte_role = ROLE_BODY;
			body_left = body_left - 32'd1;
			if (body_left == 0) begin
				r.message_end = 1'b1;
				parser_clear();
			end
		end else if (b == CH_CR) begin
			cr_seen = 1'b1;
		end else if (b == CH_LF) begin
			// A line ends only on LF right after CR; a bare LF changes nothing
			if (cr_seen) begin
				cr_seen = 1'b0;
				if (ph <= PH_VERSION) begin
					r.token_end = 1'b1;
					ph = PH_NAME;
					line_clear();
				end else if (ph == PH_NAME) begin
					if (line_empty) begin
						r.headers_done = 1'b1;
						r.body_length = len_acc;
						if (len_acc == 0) begin
							r.message_end = 1'b1;
							parser_clear();
						end else begin
							body_left = len_acc;
							ph = PH_BODY;
						end
					end else begin
						r.format_error = 1'b1;
						line_clear();
					end
				end else begin
					r.token_end = 1'b1;
					ph = PH_NAME;
					line_clear();
				end
			end
		end else begin
			cr_seen = 1'b0;
			if (ph <= PH_TARGET) begin
				if (b == CH_SPACE) begin
					r.token_end = 1'b1;
					ph = (ph == PH_METHOD) ? PH_TARGET : PH_VERSION;
				end else begin
					r.byte_role = (ph == PH_METHOD) ? ROLE_METHOD : ROLE_TARGET;
				end
			end else if (ph == PH_VERSION) begin
				if (b != CH_SPACE)
					r.byte_role = ROLE_VERSION;
			end else if (ph == PH_NAME) begin
				if (b == CH_COLON) begin
					r.token_end = 1'b1;
					len_hdr = still_match && (match_idx == NAME_LEN);
					if (len_hdr)
						len_acc = '0;
					ph = PH_VALUE;
					val_begun = 1'b0;
					pend_sp = '0;
				end else begin
					lc = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_OFS : b;
					r.byte_role = ROLE_NAME;
					if (still_match) begin
						if (match_idx < NAME_LEN && lc == name_byte(int'(match_idx)))
							match_idx = match_idx + 4'd1;
						else
							still_match = 1'b0;
					end
				end
			end else if (ph == PH_VALUE) begin
				if (b == CH_SPACE) begin
					if (val_begun && pend_sp < SPACE_MAX)
						pend_sp = pend_sp + 8'd1;
				end else begin
					r.byte_role = ROLE_VALUE;
					r.held_spaces = pend_sp;
					if (len_hdr) begin
						if (pend_sp > 0 || b < CH_ZERO || b > CH_NINE) begin
							len_hdr = 1'b0;
						end else begin
							// Saturate at the limit rather than overflow
							d = 64'(b) - 64'(CH_ZERO);
							if (d > lim || 64'(len_acc) > (lim - d) / 64'd10) begin
								len_acc = max_len;
								r.format_error = 1'b1;
							end else begin
								len_acc = 32'(64'(len_acc) * 64'd10 + d);
							end
						end
					end
					pend_sp = '0;
					val_begun = 1'b1;
				end
			end
			line_empty = 1'b0;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		fail_count++;
		$display("mismatch on beat %0d, %s: got 0x%0h, expected 0x%0h",
			beats_seen, what, got, want);
	endtask

	task automatic check_beat(input hrsp_result_t got, input hrsp_result_t want);
		if (got.byte_out !== want.byte_out)
			report_mismatch("byte_out", 32'(got.byte_out), 32'(want.byte_out));
		if (got.byte_role !== want.byte_role)
			report_mismatch("byte_role", 32'(got.byte_role), 32'(want.byte_role));
		if (got.held_spaces !== want.held_spaces)
			report_mismatch("held_spaces", 32'(got.held_spaces), 32'(want.held_spaces));
		if (got.token_end !== want.token_end)
			report_mismatch("token_end", 32'(got.token_end), 32'(want.token_end));
		if (got.headers_done !== want.headers_done)
			report_mismatch("headers_done", 32'(got.headers_done), 32'(want.headers_done));
		if (got.body_length !== want.body_length)
			report_mismatch("body_length", got.body_length, want.body_length);
		if (got.message_end !== want.message_end)
			report_mismatch("message_end", 32'(got.message_end), 32'(want.message_end));
		if (got.format_error !== want.format_error)
			report_mismatch("format_error", 32'(got.format_error), 32'(want.format_error));
	endtask

	// Result side: check each accepted beat, then pick the next ready
	always @(posedge clk) begin : result_side
		hrsp_result_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.byte_out = m_tdata[7:0];
				got.held_spaces = m_tdata[15:8];
				got.body_length = m_tdata[47:16];
				got.byte_role = m_tuser[2:0];
				got.token_end = m_tuser[3];
				got.headers_done = m_tuser[4];
				got.format_error = m_tuser[5];
				got.message_end = m_tlast;
				if (expected_beats.size() == 0)
					report_mismatch("beat with nothing expected", 32'(got.byte_out), 32'd0);
				else
					check_beat(got, expected_beats.pop_front());
				beats_seen++;
			end
			m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Drive one input beat after a random gap and hold it until accepted
	task automatic send_byte(input logic [7:0] b, input logic rst, input logic pinned,
			input hrsp_result_t pinned_res);
		hrsp_result_t predicted;
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= rst;
		predicted = parse_byte(b, rst);
		expected_beats.push_back(pinned ? pinned_res : predicted);
		bytes_sent++;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic put(input logic [7:0] b);
		send_byte(b, restart_next, 1'b0, '0);
		restart_next = 1'b0;
	endtask

	task automatic put_crlf();
		put(CH_CR);
		put(CH_LF);
	endtask

	// Drop valid and hold until every result is back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] token_char(input bit allow_colon);
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (c == CH_CR || c == CH_LF || c == CH_SPACE || (!allow_colon && c == CH_COLON))
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 5))
			0:       return CH_CR;
			1:       return CH_LF;
			2:       return CH_SPACE;
			3:       return CH_COLON;
			4:       return CH_ZERO + 8'($urandom_range(0, 9));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// One header line: length header, other header, line without colon, or stray bytes
	task automatic send_header();
		int         kind;
		int         mut;
		int         last;
		int         bad;
		int         form;
		int         words;
		logic [7:0] c;
		kind = $urandom_range(0, 9);
		if (kind <= 3) begin
			// Random case, sometimes one char short, long or wrong
			mut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
			last = (mut == 1) ? 12 : 13;
			bad = $urandom_range(0, 13);
			for (int i = 0; i <= last; i++) begin
				c = name_byte(i);
				if (c >= CH_LOW_A && c <= CH_LOW_Z && $urandom_range(0, 1))
					c = c - CASE_OFS;
				if (mut == 3 && i == bad)
					c = token_char(1'b0);
				put(c);
			end
			if (mut == 2)
				put(token_char(1'b0));
		end else begin
			repeat ($urandom_range(1, 8)) put(token_char(1'b0));
		end
		if (kind == 8) begin
			put_crlf();
		end else begin
			if (kind == 9) begin
				put(CH_LF);
				put(CH_CR);
				put(CH_CR);
			end
			put(CH_COLON);
			repeat ($urandom_range(0, 2)) put(CH_SPACE);
			if (kind <= 3) begin
				// Digits, signed, split by a space, long enough to saturate, or with junk
				form = $urandom_range(0, 9);
				if (form == 0)
					put($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
				repeat ((form == 1) ? $urandom_range(5, 11) : $urandom_range(1, 3))
					put(CH_ZERO + 8'($urandom_range(0, 9)));
				if (form == 2) begin
					put(CH_SPACE);
					repeat ($urandom_range(1, 2)) put(CH_ZERO + 8'($urandom_range(0, 9)));
				end
				if (form == 3)
					put(token_char(1'b0));
			end else begin
				words = $urandom_range(1, 3);
				for (int w = 0; w < words; w++) begin
					repeat ($urandom_range(1, 6)) put(token_char(1'b1));
					if (w < words - 1) begin
						// One gap runs the held space count into saturation
						if (!long_gap_done) begin
							long_gap_done = 1'b1;
							repeat ($urandom_range(255, 257)) put(CH_SPACE);
						end else begin
							repeat ($urandom_range(1, 3)) put(CH_SPACE);
						end
					end
				end
			end
			repeat ($urandom_range(0, 2)) put(CH_SPACE);
			put_crlf();
		end
	endtask

	// One request, mostly well formed; a cut-off body is cleared by the next restart
	task automatic send_request();
		int form;
		int n;
		if (ph != PH_METHOD || cr_seen || $urandom_range(0, 3) == 0)
			restart_next = 1'b1;
		if ($urandom_range(0, 6) == 0) begin
			repeat ($urandom_range(4, 24)) put(noise_byte());
		end else begin
			repeat ($urandom_range(1, 6)) put(token_char(1'b0));
			form = $urandom_range(0, 7);
			if (form != 0) begin
				put(CH_SPACE);
				repeat ($urandom_range(1, 8)) put(token_char(1'b1));
				if (form != 1) begin
					put(CH_SPACE);
					repeat ($urandom_range(1, 8)) begin
						put(token_char(1'b1));
						if ($urandom_range(0, 4) == 0)
							put(CH_SPACE);
					end
				end
			end
			put_crlf();
			repeat ($urandom_range(0, 4)) send_header();
			put_crlf();
			n = 0;
			while (ph == PH_BODY && n < BODY_CAP) begin
				put(noise_byte());
				n++;
			end
		end
	endtask

	task automatic row(input logic [7:0] b, input logic rst);
		stim_rows.push_back({b, rst, 1'b0, hrsp_result_t'('0)});
	endtask

	task automatic row_pin(input logic [7:0] b, input logic rst, input logic [2:0] role,
			input int held, input int tend, input int hdone,
			input int mend, input int ferr);
		hrsp_result_t r;
		r = '0;
		r.byte_out = b;
		r.byte_role = role;
		r.held_spaces = 8'(held);
		r.token_end = 1'(tend);
		r.headers_done = 1'(hdone);
		r.message_end = 1'(mend);
		r.format_error = 1'(ferr);
		stim_rows.push_back({b, rst, 1'b1, r});
	endtask

	initial begin : stimulus
		logic [31:0] lim;
		int          goal;

		// Short request line, bare LF, header without colon, trimmed value, empty body
		row_pin(8'h00, 1'b1, ROLE_METHOD, 0, 0, 0, 0, 0);
		row_pin(8'hFF, 1'b0, ROLE_METHOD, 0, 0, 0, 0, 0);
		row_pin(CH_SPACE, 1'b0, ROLE_DELIM, 0, 1, 0, 0, 0);
		row("/", 1'b0);
		row_pin(CH_LF, 1'b0, ROLE_DELIM, 0, 0, 0, 0, 0);
		row_pin(CH_CR, 1'b0, ROLE_DELIM, 0, 0, 0, 0, 0);
		row_pin(CH_LF, 1'b0, ROLE_DELIM, 0, 1, 0, 0, 0);
		row("x", 1'b0);
		row(CH_CR, 1'b0);
		row_pin(CH_LF, 1'b0, ROLE_DELIM, 0, 0, 0, 0, 1);
		row("A", 1'b0);
		row_pin(CH_COLON, 1'b0, ROLE_DELIM, 0, 1, 0, 0, 0);
		row_pin(CH_SPACE, 1'b0, ROLE_DELIM, 0, 0, 0, 0, 0);
		row("v", 1'b0);
		row(CH_SPACE, 1'b0);
		row(CH_SPACE, 1'b0);
		row_pin("w", 1'b0, ROLE_VALUE, 2, 0, 0, 0, 0);
		row(CH_SPACE, 1'b0);
		row(CH_CR, 1'b0);
		row_pin(CH_LF, 1'b0, ROLE_DELIM, 0, 1, 0, 0, 0);
		row(CH_CR, 1'b0);
		row_pin(CH_LF, 1'b0, ROLE_DELIM, 0, 0, 1, 1, 0);
		// Extra space inside the version, then restart mid-line
		row("G", 1'b0);
		row(CH_SPACE, 1'b0);
		row("/", 1'b0);
		row(CH_SPACE, 1'b0);
		row("H", 1'b0);
		row_pin(CH_SPACE, 1'b0, ROLE_DELIM, 0, 0, 0, 0, 0);
		row("1", 1'b0);
		row_pin(CH_SPACE, 1'b1, ROLE_DELIM, 0, 1, 0, 0, 0);
		row_pin("x", 1'b1, ROLE_METHOD, 0, 0, 0, 0, 0);

		max_len = MAX_BODY_RESET;
		parser_clear();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < stim_rows.size(); i++)
			send_byte(stim_rows[i].data, stim_rows[i].rst, stim_rows[i].pinned,
				stim_rows[i].res);

		// Random requests under a sequence of length limits
		for (int p = 0; p < PLAN_STEPS; p++) begin
			case (p)
				0:       lim = 32'hFFFF_FFFF;
				1:       lim = 32'd0;
				2:       lim = 32'd37;
				3:       lim = $urandom;
				4:       lim = $urandom_range(0, 2000);
				default: lim = MAX_BODY_RESET;
			endcase
			wait_drained();
			cfg_valid <= 1'b1;
			cfg_data <= lim;
			do @(posedge clk); while (!cfg_ready);
			cfg_valid <= 1'b0;
			max_len = lim;
			no_idle = (p == 3);
			goal = bytes_sent + STEP_BYTES;
			while (bytes_sent < goal) begin
				send_request();
				if ($urandom_range(0, 7) == 0)
					wait_drained();
			end
		end

		no_idle = 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && expected_beats.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
